// ===== rtl/core/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tridiagonal Thomas solver.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int FRAC_BITS = 16;
   localparam int ROW_W     = 6;
   localparam int CNT_W     = 7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SINGULAR = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [31:0] lower;
      logic signed [31:0] main_diag;
      logic signed [31:0] upper;
      logic signed [31:0] rhs_value;
      logic               last_row;
   } req_type;

   typedef struct packed {
      logic signed [31:0] solution;
      logic [5:0]         row_index;
      logic [1:0]         status;
      logic               final_res;
   } rsp_type;

   typedef enum logic [5:0] {
      OP_NONE   = 6'b000001,
      OP_LOAD   = 6'b000010,
      OP_PIVOT  = 6'b000100,
      OP_DIVC   = 6'b001000,
      OP_DIVD   = 6'b010000,
      OP_STORE  = 6'b100000
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       back_start;  // point the sweep at the last row
      logic       back_step;   // compute next x
      logic       div_start;
      logic       end_run;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic       full;
      logic       pivot_zero;
      logic [CNT_W-1:0] row_count;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

// ===== rtl/core/tts_divider.sv =====
// ----------------------------------------------------------------------------
// tts_divider
// Radix-2 restoring divider: (n << FRAC_BITS) / d, toward zero, saturated.
// ----------------------------------------------------------------------------
module tts_divider import tts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int IW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [32:0]   r_ff, r_in;
   logic [31:0]   d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic [NW:0]   mag;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[31:0], q_ff[NW-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
         d_in = den[31] ? 32'(-den) : 32'(den);
         neg_in = num[31] ^ den[31];
         r_in = '0;
         cnt_in = IW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == IW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      mag = {1'b0, q_ff};
      quot = sat32(neg_ff ? -66'($signed(mag)) : 66'($signed(mag)));
   end
   assign done = done_ff;
endmodule

// ===== rtl/core/tts_datapath.sv =====
// ----------------------------------------------------------------------------
// tts_datapath
// Row registers, pivot arithmetic, per-row stores and back substitution.
// ----------------------------------------------------------------------------
module tts_datapath import tts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);
   logic signed [31:0] upper_store [MAX_ROWS];
   logic signed [31:0] rhs_store   [MAX_ROWS];

   req_type            row_ff;
   logic signed [31:0] piv_ff, num_ff, c_ff;
   logic signed [31:0] pu_ff, pr_ff;
   logic signed [63:0] p1_ff, p2_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         err_ff, err_in;
   logic [ROW_W-1:0]   br_ff;
   logic signed [31:0] x_ff, su_ff, sr_ff;
   logic signed [63:0] bp_ff;
   logic               bphase_ff;
   logic               pz;
   logic               dstart;
   logic signed [31:0] dnum, dq;
   logic               ddone;
   logic [ROW_W-1:0]   wr;
   logic signed [31:0] lo_eff, up_eff;

   function automatic logic signed [31:0] qshift(input logic signed [63:0] p);
      return sat32(66'(p >>> FRAC_BITS));
   endfunction

   assign lo_eff = (cnt_ff == '0) ? 32'sd0 : row_ff.lower;
   assign up_eff = row_ff.last_row ? 32'sd0 : row_ff.upper;
   assign pz = (piv_ff == 32'sd0);
   assign dstart = cmd.div_start;
   assign dnum = (cmd.op == OP_DIVC) ? up_eff : num_ff;
   assign wr = cnt_ff[ROW_W-1:0];

   tts_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(piv_ff),
      .done(ddone), .quot(dq)
   );

   always_comb begin
      cnt_in = cnt_ff;
      err_in = err_ff;
      if (cmd.end_run) begin
         cnt_in = '0;
         err_in = ST_OK;
      end else if (cmd.op == OP_LOAD && cnt_ff == CNT_W'(MAX_ROWS)) begin
         if (err_ff == ST_OK) err_in = ST_OVERFLOW;
      end else if (cmd.op == OP_STORE) begin
         cnt_in = cnt_ff + 1'b1;
         if (pz && err_ff == ST_OK) err_in = ST_SINGULAR;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) row_ff <= req;
      p1_ff <= pu_ff * lo_eff;
      p2_ff <= lo_eff * pr_ff;
      if (cmd.op == OP_PIVOT) begin
         piv_ff <= sat32(66'(row_ff.main_diag) - 66'(qshift(p1_ff)));
         num_ff <= sat32(66'(row_ff.rhs_value) - 66'(qshift(p2_ff)));
      end
      if (ddone && cmd.op == OP_DIVC) c_ff <= dq;
      if (cmd.op == OP_STORE) begin
         upper_store[wr] <= pz ? 32'sd0 : c_ff;
         rhs_store[wr]   <= pz ? 32'sd0 : dq;
      end
      su_ff <= upper_store[br_ff];
      sr_ff <= rhs_store[br_ff];
      bp_ff <= su_ff * x_ff;
      if (cmd.back_start) begin
         br_ff <= ROW_W'(cnt_in - 1'b1);
         bphase_ff <= 1'b0;
      end else if (cmd.back_step) begin
         if (!bphase_ff) x_ff <= sr_ff;
         else x_ff <= sat32(66'(sr_ff) - 66'(qshift(bp_ff)));
         bphase_ff <= 1'b1;
         br_ff <= br_ff - 1'b1;
      end
      if (reset) begin
         cnt_ff <= '0;
         err_ff <= ST_OK;
         pu_ff <= '0;
         pr_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         err_ff <= err_in;
         if (cmd.end_run) begin
            pu_ff <= '0;
            pr_ff <= '0;
         end else if (cmd.op == OP_STORE) begin
            pu_ff <= pz ? 32'sd0 : c_ff;
            pr_ff <= pz ? 32'sd0 : dq;
         end
      end
   end

   // result of the step just taken; row is br+1 after decrement
   logic [ROW_W-1:0] out_row;
   assign out_row = br_ff + 1'b1;
   always_comb begin
      rsp.solution  = (err_ff != ST_OK) ? 32'sd0 : x_ff;
      rsp.row_index = out_row;
      rsp.status    = err_ff;
      rsp.final_res = (out_row == '0);
   end

   assign sts.div_done   = ddone;
   assign sts.full       = (cnt_ff == CNT_W'(MAX_ROWS));
   assign sts.pivot_zero = pz;
   assign sts.row_count  = cnt_ff;

   property p_store_room;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_STORE) |-> (cnt_ff < CNT_W'(MAX_ROWS));
   endproperty
   assert property (p_store_room) else $error("store beyond capacity");
endmodule

// ===== rtl/core/tts_controller.sv =====
// ----------------------------------------------------------------------------
// tts_controller
// Sequences row intake, pivot, two divisions, store, and back substitution.
// ----------------------------------------------------------------------------
module tts_controller import tts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_stall
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL   = 10'b0000000010,
      S_PIV   = 10'b0000000100,
      S_DIVC  = 10'b0000001000,
      S_DIVD  = 10'b0000010000,
      S_STORE = 10'b0000100000,
      S_BREAD = 10'b0001000000,
      S_BMUL  = 10'b0010000000,
      S_BOUT  = 10'b0100000000,
      S_BWAIT = 10'b1000000000
   } state_type;

   state_type st_ff, st_in;
   logic      last_ff, last_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic      vld_ff, vld_in;
   logic [1:0] wait_ff, wait_in;

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = vld_ff;

   always_comb begin
      st_in = st_ff; last_in = last_ff; left_in = left_ff; vld_in = vld_ff;
      wait_in = wait_ff;
      cmd = '{op: OP_NONE, back_start: 1'b0, back_step: 1'b0, div_start: 1'b0,
              end_run: 1'b0};
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               last_in = req_last;
               st_in = sts.full ? (req_last ? S_BREAD : S_IDLE) : S_MUL;
               if (sts.full && req_last) cmd.back_start = 1'b1;
               wait_in = 2'd0;
            end
         end
         S_MUL: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == 2'd1) st_in = S_PIV;
         end
         S_PIV: begin
            cmd.op = OP_PIVOT;
            st_in = S_DIVC;
            wait_in = 2'd0;
         end
         S_DIVC: begin
            cmd.op = OP_DIVC;
            if (wait_ff == 2'd0) begin
               cmd.div_start = 1'b1;
               wait_in = 2'd1;
            end else if (sts.div_done) begin
               st_in = S_DIVD;
               wait_in = 2'd0;
            end
         end
         S_DIVD: begin
            cmd.op = OP_DIVD;
            if (wait_ff == 2'd0) begin
               cmd.div_start = 1'b1;
               wait_in = 2'd1;
            end else if (sts.div_done) begin
               st_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.op = OP_STORE;
            st_in = last_ff ? S_BREAD : S_IDLE;
            if (last_ff) cmd.back_start = 1'b1;
         end
         S_BREAD: begin
            left_in = (st_ff == S_BREAD && wait_ff == 2'd3) ? left_ff : sts.row_count;
            wait_in = 2'd0;
            st_in = S_BMUL;
         end
         S_BMUL: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == 2'd2) begin
               cmd.back_step = 1'b1;
               st_in = S_BOUT;
               vld_in = 1'b1;
               left_in = left_ff - 1'b1;
            end
         end
         S_BOUT: begin
            if (!rsp_stall) begin
               vld_in = 1'b0;
               if (left_ff == '0) begin
                  cmd.end_run = 1'b1;
                  st_in = S_IDLE;
               end else begin
                  st_in = S_BWAIT;
                  wait_in = 2'd0;
               end
            end
         end
         S_BWAIT: begin
            st_in = S_BMUL;
            wait_in = 2'd0;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      if (reset) begin
         st_ff <= S_IDLE;
         last_ff <= 1'b0;
         vld_ff <= 1'b0;
         wait_ff <= 2'd0;
      end else begin
         st_ff <= st_in;
         last_ff <= last_in;
         vld_ff <= vld_in;
         wait_ff <= wait_in;
      end
   end

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (st_ff != S_IDLE) |-> req_stall;
   endproperty
   assert property (p_no_accept_busy) else $error("row taken while busy");

   property p_valid_only_bout;
      @(posedge clock) disable iff (reset) rsp_valid |-> (st_ff == S_BOUT);
   endproperty
   assert property (p_valid_only_bout) else $error("result outside output state");

   property p_end_idle;
      @(posedge clock) disable iff (reset) cmd.end_run |=> (st_ff == S_IDLE);
   endproperty
   assert property (p_end_idle) else $error("run end without idle");
endmodule

// ===== rtl/core/tridiagonal_thomas_solver_top.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver_top
// Thomas-algorithm tridiagonal solver, signed Q16.16, saturating.
//
//   channel | direction | payload
//   req_    | in        | req_type: one row of the system
//   rsp_    | out       | rsp_type: one solution component, last row first
//
// A forward row runs two serial 48-step divisions.
// Each back-substitution result is held while the output is stalled.
// Reset is synchronous and clears the run; row stores are not cleared.
// Rows are refused while a row or the back sweep is in progress.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver_top import tts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   tts_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_last(req_data.last_row), .req_stall(req_stall), .sts(sts), .cmd(cmd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
   );

   tts_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp(rsp_data)
   );
endmodule
